>>> sv/gce_pkg.sv
// package for the glyph column expander: phase codes, font rom contents
// and the character to glyph lookup; depends on nothing
package gce_pkg;

   localparam int DISPLAY_WIDTH_DEFAULT = 16;
   localparam int GLYPH_COLUMNS = 5;
   localparam int FONT_ENTRIES = 29;
   localparam logic [4:0] FONT_BLOCK = 5'd28;
   localparam logic [9:0] CHAR_TOTAL_MAX = 10'd1023;
   localparam logic [11:0] COLUMNS_MAX = 12'd4095;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEAD,
      PH_GLYPH,
      PH_TRAIL
   } phase_type;

   // one word per glyph, leftmost column in the top byte, bit 7 is row r0
   localparam logic [39:0] FONT_ROM [FONT_ENTRIES] = '{
      40'h7F_90_90_90_7F, // A
      40'hFF_91_91_91_6E, // B
      40'h7E_81_81_81_42, // C
      40'hFF_81_81_81_7E, // D
      40'hFF_89_89_89_81, // E
      40'hFF_88_88_88_80, // F
      40'h7E_81_81_85_47, // G
      40'hFF_08_08_08_FF, // H
      40'h00_00_FF_00_00, // I
      40'h06_01_01_81_FE, // J
      40'hFF_08_14_22_41, // K
      40'hFF_01_01_01_01, // L
      40'hFF_20_10_20_FF, // M
      40'hFF_20_10_08_FF, // N
      40'h7E_81_81_81_7E, // O
      40'hFF_88_88_88_70, // P
      40'h7E_81_81_82_7D, // Q
      40'hFF_88_88_88_77, // R
      40'h71_89_89_89_86, // S
      40'h80_80_FF_80_80, // T
      40'hFE_01_01_01_FE, // U
      40'hE0_1C_07_1C_E0, // V
      40'hFF_02_3C_02_FF, // W
      40'hC3_24_18_24_C3, // X
      40'hC0_20_1F_20_C0, // Y
      40'h83_85_99_A1_C1, // Z
      40'h00_00_FD_00_00, // exclamation mark
      40'h00_00_00_00_00, // space
      40'hFF_FF_FF_FF_FF  // underscore and unknown bytes
   };

   function automatic logic [4:0] font_index(input logic [7:0] code);
      logic [4:0] idx;
      if (code >= 8'h41 && code <= 8'h5A) begin
         idx = 5'(code - 8'h41);
      end else if (code == 8'h21) begin
         idx = 5'd26;
      end else if (code == 8'h20) begin
         idx = 5'd27;
      end else begin
         idx = FONT_BLOCK;
      end
      return idx;
   endfunction

   function automatic logic [7:0] glyph_column(input logic [4:0] g, input logic [2:0] c);
      logic [39:0] row;
      logic [7:0] col;
      row = FONT_ROM[g];
      col = 8'h00;
      case (c)
         3'd0: col = row[39:32];
         3'd1: col = row[31:24];
         3'd2: col = row[23:16];
         3'd3: col = row[15:8];
         3'd4: col = row[7:0];
         default: col = 8'h00;
      endcase
      return col;
   endfunction

endpackage

>>> sv/glyph_column_expander.sv
// glyph column expander: turns message characters into led-matrix column words
// an item's first column word reaches rsp through the sequencer state, the font rom stage and the output word register
// throughput: one column word per cycle while rsp_ready allows; a character gives 6 words, plus display_width
// for the leading pad of a message and display_width for the trailing pad at its end
// the next item is taken on the cycle the current item's last column enters the font rom stage
// reset (synchronous, active high) empties the pipeline and clears the message state
module glyph_column_expander #(
   parameter int DisplayWidth = gce_pkg::DISPLAY_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_has_char,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_column_bits,
   output logic        rsp_last_of_run,
   output logic        rsp_message_done,
   output logic [11:0] rsp_message_columns
);
   import gce_pkg::*;

   // counter covers both the pad runs and the six columns of a glyph
   localparam int CntWidth = ($clog2(DisplayWidth) > 3) ? $clog2(DisplayWidth) : 3;
   localparam logic [CntWidth-1:0] PadLast = CntWidth'(DisplayWidth - 1);
   localparam logic [CntWidth-1:0] GlyphLast = CntWidth'(GLYPH_COLUMNS);

   // column sequencer state
   phase_type             phase_ff, phase_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   // the item being expanded
   logic [4:0]            glyph_ff;
   logic                  has_ff;
   logic                  end_ff;
   logic [11:0]           len_ff;

   // message state
   logic                  inside_ff;
   logic [9:0]            total_ff;

   // font rom stage
   logic                  s1_valid_ff;
   logic                  s1_blank_ff;
   logic                  s1_last_ff;
   logic                  s1_done_ff;
   logic [11:0]           s1_len_ff;
   logic [7:0]            rom_q_ff;

   // output word register
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_bits_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;
   logic [11:0]           rsp_len_ff;

   logic                  out_move;
   logic                  s1_free;
   logic                  emit;
   logic                  gen_last;
   logic                  desc_blank;
   logic                  desc_last;
   logic                  desc_done;
   logic                  req_fire;
   logic                  item_active;
   logic [9:0]            total_new;
   logic [13:0]           len_full;
   phase_type             start_phase;

   // handshake between the stages
   assign out_move = !rsp_valid_ff || rsp_ready;
   assign s1_free  = !s1_valid_ff || out_move;
   assign emit     = (phase_ff != PH_IDLE) && s1_free;

   // a new item is taken when idle, or as the running item's last column goes out
   assign req_ready   = (phase_ff == PH_IDLE) || (emit && gen_last &&
                        (phase_ff == PH_TRAIL || (phase_ff == PH_GLYPH && !end_ff)));
   assign req_fire    = req_valid && req_ready;
   assign item_active = req_has_char || req_end_of_message;

   // leading pad only when no message is open
   assign start_phase = !inside_ff ? PH_LEAD : (req_has_char ? PH_GLYPH : PH_TRAIL);

   // character count saturates, scroll length is chars*6 + display width, saturated
   assign total_new = (req_has_char && total_ff != CHAR_TOTAL_MAX) ? total_ff + 10'd1
                                                                   : total_ff;
   assign len_full  = {2'b00, total_new, 2'b00} + {3'b000, total_new, 1'b0}
                      + 14'(DisplayWidth);

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (emit) begin
         if (gen_last) begin
            cnt_in = '0;
            unique case (phase_ff)
               PH_LEAD:  phase_in = has_ff ? PH_GLYPH : PH_TRAIL;
               PH_GLYPH: phase_in = end_ff ? PH_TRAIL : PH_IDLE;
               PH_TRAIL: phase_in = PH_IDLE;
               default:  phase_in = PH_IDLE;
            endcase
         end else begin
            cnt_in = cnt_ff + CntWidth'(1);
         end
      end
      if (req_fire && item_active) begin
         phase_in = start_phase;
         cnt_in   = '0;
      end
   end

   // sequencer outputs: what the current column is
   always_comb begin
      gen_last   = 1'b0;
      desc_blank = 1'b1;
      desc_last  = 1'b0;
      desc_done  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            gen_last = 1'b0;
         end
         PH_LEAD: begin
            gen_last = (cnt_ff == PadLast);
         end
         PH_GLYPH: begin
            gen_last   = (cnt_ff == GlyphLast);
            desc_blank = (cnt_ff == GlyphLast);
            desc_last  = (cnt_ff == GlyphLast) && !end_ff;
         end
         PH_TRAIL: begin
            gen_last  = (cnt_ff == PadLast);
            desc_last = (cnt_ff == PadLast);
            desc_done = (cnt_ff == PadLast);
         end
         default: begin
            gen_last = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         inside_ff    <= 1'b0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         if (req_fire && item_active) begin
            inside_ff <= !req_end_of_message;
            total_ff  <= req_end_of_message ? 10'd0 : total_new;
         end
         if (s1_free) begin
            s1_valid_ff <= emit;
         end
         if (out_move) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // item payload, captured on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         glyph_ff <= font_index(req_char_code);
         has_ff   <= req_has_char;
         end_ff   <= req_end_of_message;
         len_ff   <= (len_full > 14'(COLUMNS_MAX)) ? COLUMNS_MAX : len_full[11:0];
      end
   end

   // font rom, registered read in the stage ahead of the output word register
   always_ff @(posedge clock) begin
      if (emit) begin
         rom_q_ff    <= glyph_column(glyph_ff, cnt_ff[2:0]);
         s1_blank_ff <= desc_blank;
         s1_last_ff  <= desc_last;
         s1_done_ff  <= desc_done;
         s1_len_ff   <= desc_done ? len_ff : 12'd0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (out_move && s1_valid_ff) begin
         rsp_bits_ff <= s1_blank_ff ? 8'h00 : rom_q_ff;
         rsp_last_ff <= s1_last_ff;
         rsp_done_ff <= s1_done_ff;
         rsp_len_ff  <= s1_len_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_column_bits     = rsp_bits_ff;
   assign rsp_last_of_run     = rsp_last_ff;
   assign rsp_message_done    = rsp_done_ff;
   assign rsp_message_columns = rsp_len_ff;

   // a message end is always the last word of its item
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> rsp_last_of_run)
      else $error("message end word without end of run");

   // length field only carries a value on the message end word
   a_len_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_done |-> rsp_message_columns == 12'd0)
      else $error("length reported outside the message end word");

   // reported length never below the trailing pad
   a_len_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> rsp_message_columns >= 12'(DisplayWidth))
      else $error("message length below display width");

   // a closed message keeps no character count
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> total_ff == 10'd0)
      else $error("character count held outside a message");

   // an item that produces words starts the sequencer
   a_item_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && item_active |=> phase_ff != PH_IDLE)
      else $error("accepted item did not start a run");

endmodule
